>>> design/rhc_pkg.sv
// Shared types and constants of the RGB/HSL pixel converter.
package rhc_pkg;

	// Fixed-point format of hue, saturation and lightness
	localparam int FRAC_BITS = 15;
	localparam int HSL_W = FRAC_BITS + 1;
	localparam logic [HSL_W-1:0] ONE_Q = HSL_W'(1) << FRAC_BITS;
	// Intermediate HSL to RGB values in Q(2F) with two guard bits
	localparam int Q2_W = 2 * FRAC_BITS + 2;

	// Pipeline shape: two front stages, then the divider stages
	localparam int DIV_STAGES = 8;
	localparam int NUM_STAGES = DIV_STAGES + 2;

	typedef enum logic {
		MODE_TO_HSL = 1'b0,
		MODE_TO_RGB = 1'b1
	} mode_t;

	typedef struct packed {
		logic        mode;
		logic [7:0]  in_red;
		logic [7:0]  in_green;
		logic [7:0]  in_blue;
		logic [15:0] in_hue;
		logic [15:0] in_saturation;
		logic [15:0] in_lightness;
	} pixel_t;

	typedef struct packed {
		logic [7:0]  out_red;
		logic [7:0]  out_green;
		logic [7:0]  out_blue;
		logic [14:0] out_hue;
		logic [15:0] out_saturation;
		logic [15:0] out_lightness;
	} result_t;

	// Per-item control carried alongside the divider
	typedef struct packed {
		mode_t            mode;
		logic             gray;
		logic [HSL_W-1:0] light;
	} side_t;

	// Clamped HSL operands for the RGB back end
	typedef struct packed {
		logic [FRAC_BITS-1:0] hue;
		logic [HSL_W-1:0]     sat;
		logic [HSL_W-1:0]     light;
		logic [Q2_W-1:0]      ls;
	} hsl_op_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

endpackage

>>> design/rhc_stream_if.sv
// Valid/ready stream channel carrying one payload per transfer.
interface rhc_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> design/rhc_front.sv
// Front stages: input register, channel min/max, lightness and divider operands.
module rhc_front (
	input  logic                          clk,
	input  logic [1:0]                    en,
	input  rhc_pkg::pixel_t               px,
	output logic [7:0]                    sat_num_s2,
	output logic [7:0]                    sat_den_s2,
	output logic [10:0]                   hue_num_s2,
	output logic [10:0]                   hue_den_s2,
	output rhc_pkg::side_t                side_s2,
	output rhc_pkg::hsl_op_t              hsl_s2
);
	import rhc_pkg::*;

	pixel_t      px_s1;
	logic [7:0]  r, g, b, mx, mn, d, den;
	logic [8:0]  sum;
	logic [14:0] y;
	logic [15:0] lq;
	logic [10:0] d6;
	logic [11:0] n_raw, n_fix;
	logic [HSL_W-1:0] s_c, l_c;

	// Register the incoming pixel
	always_ff @(posedge clk) begin
		if (en[0]) begin
			px_s1 <= px;
		end
	end

	// Largest and smallest channel
	always_comb begin
		r = px_s1.in_red;
		g = px_s1.in_green;
		b = px_s1.in_blue;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		sum = 9'(mx) + 9'(mn);
		den = (sum < 9'd255) ? sum[7:0] : 8'(10'd510 - 10'(sum));
		d6 = 11'({d, 2'b0}) + 11'({d, 1'b0});
	end

	// Lightness: sum * 2^14 / 255 split as 64*sum + floor(64*sum / 255)
	always_comb begin
		y = {sum, 6'b0};
		lq = (16'(y) + 16'(y >> 8) + 16'd1) >> 8;
	end

	// Hue numerator, wrapped into one turn
	always_comb begin
		if (r == mx) begin
			n_raw = 12'(g) - 12'(b);
		end else if (g == mx) begin
			n_raw = 12'({d, 1'b0}) + 12'(b) - 12'(r);
		end else begin
			n_raw = 12'({d, 2'b0}) + 12'(r) - 12'(g);
		end
		n_fix = n_raw[11] ? n_raw + 12'(d6) : n_raw;
	end

	// Clamp saturation and lightness to one
	always_comb begin
		s_c = (px_s1.in_saturation > 16'(ONE_Q)) ? ONE_Q : HSL_W'(px_s1.in_saturation);
		l_c = (px_s1.in_lightness > 16'(ONE_Q)) ? ONE_Q : HSL_W'(px_s1.in_lightness);
	end

	// Register the divider operands and the HSL operands
	always_ff @(posedge clk) begin
		if (en[1]) begin
			sat_num_s2     <= d;
			sat_den_s2     <= den;
			hue_num_s2     <= n_fix[10:0];
			hue_den_s2     <= d6;
			side_s2.mode   <= mode_t'(px_s1.mode);
			side_s2.gray   <= (d == 8'd0);
			side_s2.light  <= HSL_W'(16'(y) + lq);
			hsl_s2.hue     <= px_s1.in_hue[FRAC_BITS-1:0];
			hsl_s2.sat     <= s_c;
			hsl_s2.light   <= l_c;
			hsl_s2.ls      <= Q2_W'(l_c) * Q2_W'(s_c);
		end
	end

endmodule

>>> design/rhc_div.sv
// Pipelined restoring divider: (num << (Q_W-1)) / den, Q_W/STAGES quotient bits per stage.
module rhc_div #(
	parameter int NUM_W  = 8,
	parameter int DEN_W  = 8,
	parameter int Q_W    = 16,
	parameter int STAGES = 8
) (
	input  logic              clk,
	input  logic [STAGES-1:0] en,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic [Q_W-1:0]    quo
);
	localparam int RW  = DEN_W + 1;
	localparam int SPS = Q_W / STAGES;

	logic [RW-1:0]    rem_s [STAGES];
	logic [DEN_W-1:0] den_s [STAGES];
	logic [Q_W-1:0]   quo_s [STAGES];

	for (genvar st = 0; st < STAGES; st++) begin : g_stage
		logic [RW-1:0]    rem_in, rem_nx;
		logic [DEN_W-1:0] den_in;
		logic [Q_W-1:0]   quo_in, quo_nx;

		if (st == 0) begin : g_first
			assign rem_in = RW'(num);
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[st-1];
			assign den_in = den_s[st-1];
			assign quo_in = quo_s[st-1];
		end

		// Resolve SPS quotient bits; the very first bit takes no shift
		always_comb begin
			rem_nx = rem_in;
			quo_nx = quo_in;
			for (int k = 0; k < SPS; k++) begin
				if (!(st == 0 && k == 0)) begin
					rem_nx = {rem_nx[RW-2:0], 1'b0};
				end
				if (rem_nx >= {1'b0, den_in}) begin
					rem_nx = rem_nx - {1'b0, den_in};
					quo_nx = {quo_nx[Q_W-2:0], 1'b1};
				end else begin
					quo_nx = {quo_nx[Q_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[st]) begin
				rem_s[st] <= rem_nx;
				den_s[st] <= den_in;
				quo_s[st] <= quo_nx;
			end
		end
	end

	assign quo = quo_s[STAGES-1];

endmodule

>>> design/rhc_rgb.sv
// HSL to RGB back end: v and m, sextant blend, byte scaling over four stages.
module rhc_rgb (
	input  logic             clk,
	input  logic [3:0]       en,
	input  rhc_pkg::hsl_op_t hsl,
	output rhc_pkg::rgb_t    rgb_s6
);
	import rhc_pkg::*;

	localparam int H6_W = FRAC_BITS + 3;

	logic [Q2_W-1:0]      l2, s2, v_c, m_c, span_c;
	logic [H6_W-1:0]      h6;
	logic [HSL_W+7:0]     gprod;
	logic [7:0]           gbyte_c;

	logic [Q2_W-1:0]      v_s3, m_s3, span_s3;
	logic [2:0]           sext_s3;
	logic [FRAC_BITS-1:0] fract_s3;
	logic                 zero_s3;
	logic [7:0]           gbyte_s3;

	logic [Q2_W-1:0]      phi_s4, v_s4, m_s4;
	logic [FRAC_BITS-1:0] plo_s4;
	logic [2:0]           sext_s4;
	logic                 zero_s4;
	logic [7:0]           gbyte_s4;
	logic [2*FRAC_BITS-1:0] lo_prod;

	logic [Q2_W-1:0]      vsf, mid1, mid2, cr_c, cg_c, cb_c;
	logic [Q2_W-1:0]      cr_s5, cg_s5, cb_s5;
	logic                 zero_s5;
	logic [7:0]           gbyte_s5;

	// Scale a Q(2F) channel to a byte, truncating and clamping
	function automatic logic [7:0] to_byte(input logic [Q2_W-1:0] x);
		logic [Q2_W+7:0] p;
		logic [Q2_W+7:0] q;
		p = {x, 8'b0} - (Q2_W + 8)'(x);
		q = p >> (2 * FRAC_BITS);
		to_byte = (q > (Q2_W + 8)'(255)) ? 8'hFF : q[7:0];
	endfunction

	// Stage three: v, m, span and the hue sextant
	always_comb begin
		l2 = Q2_W'(hsl.light);
		s2 = Q2_W'(hsl.sat);
		if ({hsl.light, 1'b0} <= {1'b0, ONE_Q}) begin
			v_c = (l2 << FRAC_BITS) + hsl.ls;
		end else begin
			v_c = ((l2 + s2) << FRAC_BITS) - hsl.ls;
		end
		m_c = (l2 << (FRAC_BITS + 1)) - v_c;
		span_c = v_c - m_c;
		h6 = H6_W'({hsl.hue, 2'b0}) + H6_W'({hsl.hue, 1'b0});
		gprod = {hsl.light, 8'b0} - (HSL_W + 8)'(hsl.light);
		gbyte_c = ((gprod >> FRAC_BITS) > (HSL_W + 8)'(255)) ? 8'hFF
			: 8'(gprod >> FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			v_s3     <= v_c;
			m_s3     <= m_c;
			span_s3  <= span_c;
			sext_s3  <= h6[H6_W-1:FRAC_BITS];
			fract_s3 <= h6[FRAC_BITS-1:0];
			zero_s3  <= (v_c == '0);
			gbyte_s3 <= gbyte_c;
		end
	end

	// Stage four: span times fraction as high and low partial products
	assign lo_prod = (2 * FRAC_BITS)'(span_s3[FRAC_BITS-1:0]) * (2 * FRAC_BITS)'(fract_s3);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			phi_s4   <= Q2_W'(span_s3[Q2_W-1:FRAC_BITS]) * Q2_W'(fract_s3);
			plo_s4   <= lo_prod[2*FRAC_BITS-1:FRAC_BITS];
			v_s4     <= v_s3;
			m_s4     <= m_s3;
			sext_s4  <= sext_s3;
			zero_s4  <= zero_s3;
			gbyte_s4 <= gbyte_s3;
		end
	end

	// Stage five: blend and route by sextant
	always_comb begin
		vsf  = phi_s4 + Q2_W'(plo_s4);
		mid1 = m_s4 + vsf;
		mid2 = v_s4 - vsf;
		case (sext_s4)
			3'd0: begin cr_c = v_s4; cg_c = mid1; cb_c = m_s4; end
			3'd1: begin cr_c = mid2; cg_c = v_s4; cb_c = m_s4; end
			3'd2: begin cr_c = m_s4; cg_c = v_s4; cb_c = mid1; end
			3'd3: begin cr_c = m_s4; cg_c = mid2; cb_c = v_s4; end
			3'd4: begin cr_c = mid1; cg_c = m_s4; cb_c = v_s4; end
			default: begin cr_c = v_s4; cg_c = m_s4; cb_c = mid2; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			cr_s5    <= cr_c;
			cg_s5    <= cg_c;
			cb_s5    <= cb_c;
			zero_s5  <= zero_s4;
			gbyte_s5 <= gbyte_s4;
		end
	end

	// Stage six: bytes, or lightness on all channels when v is zero
	always_ff @(posedge clk) begin
		if (en[3]) begin
			rgb_s6.red   <= zero_s5 ? gbyte_s5 : to_byte(cr_s5);
			rgb_s6.green <= zero_s5 ? gbyte_s5 : to_byte(cg_s5);
			rgb_s6.blue  <= zero_s5 ? gbyte_s5 : to_byte(cb_s5);
		end
	end

endmodule

>>> design/rgb_hsl_color_converter.sv
// RGB/HSL pixel converter: one pixel per clock in both directions when the output
// is not stalled, through a ten-stage pipeline. Its depth is set by the restoring
// divider that forms the 16-bit saturation and hue quotients over eight stages;
// the HSL to RGB path runs alongside it and waits in the carry registers. Each
// stage advances on its own, so bubbles are squeezed out and input keeps flowing
// while a result waits, as long as an earlier stage is empty. Saturation and
// lightness are unsigned Q1.15; hue is taken as Q1.15 and wrapped to Q0.15.
module rgb_hsl_color_converter (
	input  logic         clk,
	input  logic         arst_n,
	rhc_stream_if.sink   pixel,
	rhc_stream_if.source result
);
	import rhc_pkg::*;

	logic [NUM_STAGES-1:0] v_q;
	logic [NUM_STAGES-1:0] en;

	logic [7:0]  sat_num_s2, sat_den_s2;
	logic [10:0] hue_num_s2, hue_den_s2;
	side_t       side_s2;
	hsl_op_t     hsl_s2;
	rgb_t        rgb_s6;
	logic [15:0] sat_quo, hue_quo;

	// Carry registers, indexed by stage number minus one
	side_t side_s [2:NUM_STAGES-1];
	rgb_t  rgb_s  [6:NUM_STAGES-1];

	side_t   side_out;
	rgb_t    rgb_out;
	result_t res;

	// Stage enables: a stage loads when empty or when its successor moves
	always_comb begin
		en[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || result.ready;
		for (int i = NUM_STAGES - 2; i >= 0; i--) begin
			en[i] = !v_q[i] || en[i+1];
		end
	end

	assign pixel.ready = en[0];

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= pixel.valid;
			for (int i = 1; i < NUM_STAGES; i++) begin
				if (en[i]) v_q[i] <= v_q[i-1];
			end
		end
	end

	rhc_front u_front (
		.clk        (clk),
		.en         (en[1:0]),
		.px         (pixel.data),
		.sat_num_s2 (sat_num_s2),
		.sat_den_s2 (sat_den_s2),
		.hue_num_s2 (hue_num_s2),
		.hue_den_s2 (hue_den_s2),
		.side_s2    (side_s2),
		.hsl_s2     (hsl_s2)
	);

	rhc_div #(
		.NUM_W  (8),
		.DEN_W  (8),
		.Q_W    (16),
		.STAGES (DIV_STAGES)
	) u_sat_div (
		.clk (clk),
		.en  (en[NUM_STAGES-1:2]),
		.num (sat_num_s2),
		.den (sat_den_s2),
		.quo (sat_quo)
	);

	rhc_div #(
		.NUM_W  (11),
		.DEN_W  (11),
		.Q_W    (16),
		.STAGES (DIV_STAGES)
	) u_hue_div (
		.clk (clk),
		.en  (en[NUM_STAGES-1:2]),
		.num (hue_num_s2),
		.den (hue_den_s2),
		.quo (hue_quo)
	);

	rhc_rgb u_rgb (
		.clk    (clk),
		.en     (en[5:2]),
		.hsl    (hsl_s2),
		.rgb_s6 (rgb_s6)
	);

	// Carry mode, gray flag, lightness and RGB bytes to the output stage
	always_ff @(posedge clk) begin
		if (en[2]) side_s[2] <= side_s2;
		for (int i = 3; i < NUM_STAGES; i++) begin
			if (en[i]) side_s[i] <= side_s[i-1];
		end
		if (en[6]) rgb_s[6] <= rgb_s6;
		for (int i = 7; i < NUM_STAGES; i++) begin
			if (en[i]) rgb_s[i] <= rgb_s[i-1];
		end
	end

	// Select fields by direction; zero the unused ones
	always_comb begin
		side_out = side_s[NUM_STAGES-1];
		rgb_out  = rgb_s[NUM_STAGES-1];
		res = '0;
		if (side_out.mode == MODE_TO_HSL) begin
			res.out_lightness = 16'(side_out.light);
			if (!side_out.gray) begin
				res.out_hue        = hue_quo[14:0];
				res.out_saturation = sat_quo;
			end
		end else begin
			res.out_red   = rgb_out.red;
			res.out_green = rgb_out.green;
			res.out_blue  = rgb_out.blue;
		end
	end

	assign result.valid = v_q[NUM_STAGES-1];
	assign result.data  = res;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.ready) |=> v_q[0])
		else $error("accepted pixel did not reach stage one");

	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel.ready |-> v_q[0])
		else $error("input held off with an empty first stage");

	a_stall_backs_up: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q[NUM_STAGES-2] && !en[NUM_STAGES-2]) |-> v_q[NUM_STAGES-1])
		else $error("stage stalled behind an empty output stage");

endmodule

>>> verif/rgb_hsl_color_converter_chk.sv
// Checker for the RGB/HSL converter: watches both channels, predicts and compares.
module rgb_hsl_color_converter_chk (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pix_valid,
	input  logic             pix_ready,
	input  rhc_pkg::pixel_t  pix_data,
	input  logic             res_valid,
	input  logic             res_ready,
	input  rhc_pkg::result_t res_data,
	output int               fail_count,
	output int               pending
);
	import rhc_pkg::*;

	result_t expected_q[$];

	// Scale a Q(2F) channel to a byte, saturating
	function automatic logic [7:0] q2_to_byte(input longint unsigned x);
		longint unsigned b;
		b = (x * 255) >> (2 * FRAC_BITS);
		return (b > 255) ? 8'd255 : b[7:0];
	endfunction

	// Convert one pixel in the direction its mode selects
	function automatic result_t convert_pixel(input pixel_t p);
		result_t r;
		longint unsigned one, rd, gr, bl, mx, mn, d, sum, h, s, l;
		longint unsigned v2, m2, span, h6, sext, fr, vsf, mid1, mid2, cr, cg, cb, c;
		longint n;
		one = longint'(1) << FRAC_BITS;
		r = '0;
		if (p.mode == MODE_TO_HSL) begin
			rd = p.in_red;
			gr = p.in_green;
			bl = p.in_blue;
			mx = rd; mn = rd;
			if (gr > mx) mx = gr;
			if (bl > mx) mx = bl;
			if (gr < mn) mn = gr;
			if (bl < mn) mn = bl;
			d = mx - mn;
			sum = mx + mn;
			r.out_lightness = 16'((sum * one) / 510);
			if (d != 0) begin
				if (sum < 255) r.out_saturation = 16'((d * one) / sum);
				else r.out_saturation = 16'((d * one) / (510 - sum));
				if (rd == mx) n = longint'(gr) - longint'(bl);
				else if (gr == mx) n = longint'(2 * d) + longint'(bl) - longint'(rd);
				else n = longint'(4 * d) + longint'(rd) - longint'(gr);
				if (n < 0) n += longint'(6 * d);
				r.out_hue = 15'((longint'(n) * one) / (6 * d));
			end
		end else begin
			h = p.in_hue & (one - 1);
			s = (p.in_saturation > one) ? one : p.in_saturation;
			l = (p.in_lightness > one) ? one : p.in_lightness;
			if (2 * l <= one) v2 = l * (one + s);
			else v2 = (l + s) * one - l * s;
			if (v2 == 0) begin
				c = (l * 255) >> FRAC_BITS;
				r.out_red = (c > 255) ? 8'd255 : c[7:0];
				r.out_green = r.out_red;
				r.out_blue = r.out_red;
			end else begin
				m2 = 2 * l * one - v2;
				span = v2 - m2;
				h6 = h * 6;
				sext = h6 >> FRAC_BITS;
				fr = h6 & (one - 1);
				vsf = (span >> FRAC_BITS) * fr + (((span & (one - 1)) * fr) >> FRAC_BITS);
				mid1 = m2 + vsf;
				mid2 = v2 - vsf;
				case (sext)
					0: begin cr = v2; cg = mid1; cb = m2; end
					1: begin cr = mid2; cg = v2; cb = m2; end
					2: begin cr = m2; cg = v2; cb = mid1; end
					3: begin cr = m2; cg = mid2; cb = v2; end
					4: begin cr = mid1; cg = m2; cb = v2; end
					default: begin cr = v2; cg = m2; cb = mid2; end
				endcase
				r.out_red = q2_to_byte(cr);
				r.out_green = q2_to_byte(cg);
				r.out_blue = q2_to_byte(cb);
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	assign pending = expected_q.size();

	// Queue predictions on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			fail_count = 0;
			expected_q.delete();
		end else begin
			if (res_valid && res_ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					want = expected_q.pop_front();
					if (res_data.out_red != want.out_red)
						report_mismatch("out_red", res_data.out_red, want.out_red);
					if (res_data.out_green != want.out_green)
						report_mismatch("out_green", res_data.out_green, want.out_green);
					if (res_data.out_blue != want.out_blue)
						report_mismatch("out_blue", res_data.out_blue, want.out_blue);
					if (res_data.out_hue != want.out_hue)
						report_mismatch("out_hue", res_data.out_hue, want.out_hue);
					if (res_data.out_saturation != want.out_saturation)
						report_mismatch("out_saturation", res_data.out_saturation,
							want.out_saturation);
					if (res_data.out_lightness != want.out_lightness)
						report_mismatch("out_lightness", res_data.out_lightness,
							want.out_lightness);
				end
			end
			if (pix_valid && pix_ready)
				expected_q.push_back(convert_pixel(pix_data));
		end
	end

endmodule

>>> verif/rgb_hsl_color_converter_tb.sv
// Testbench top for the RGB/HSL converter: clock, reset, stimulus and verdict.
module rgb_hsl_color_converter_tb;
	import rhc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 1950;

	logic   clk;
	logic   arst_n;
	int     fail_count;
	int     pending;
	int     idle_cycles;
	bit     calm;
	pixel_t dir_q[$];

	rhc_stream_if #(.T(pixel_t))  pixel_ch ();
	rhc_stream_if #(.T(result_t)) result_ch ();

	rgb_hsl_color_converter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel_ch.sink),
		.result (result_ch.source)
	);

	rgb_hsl_color_converter_chk u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pixel_ch.valid),
		.pix_ready  (pixel_ch.ready),
		.pix_data   (pixel_ch.data),
		.res_valid  (result_ch.valid),
		.res_ready  (result_ch.ready),
		.res_data   (result_ch.data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Stall the result side at random, except in the calm stretch
	always @(negedge clk) begin
		result_ch.ready <= calm || ($urandom_range(99) >= 18);
	end

	// End the run when nothing has moved for too long
	always @(posedge clk) begin
		if (!arst_n || (pixel_ch.valid && pixel_ch.ready)
			|| (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic pixel_t make_rgb(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		pixel_t p;
		p = '0;
		p.mode = MODE_TO_HSL;
		p.in_red = r;
		p.in_green = g;
		p.in_blue = b;
		p.in_hue = 16'($urandom);
		p.in_saturation = 16'($urandom);
		p.in_lightness = 16'($urandom);
		return p;
	endfunction

	function automatic pixel_t make_hsl(input logic [15:0] h, input logic [15:0] s,
		input logic [15:0] l);
		pixel_t p;
		p = '0;
		p.mode = MODE_TO_RGB;
		p.in_red = 8'($urandom);
		p.in_green = 8'($urandom);
		p.in_blue = 8'($urandom);
		p.in_hue = h;
		p.in_saturation = s;
		p.in_lightness = l;
		return p;
	endfunction

	// Pick a Q1.15 value, mostly in range, sometimes at or past one
	function automatic logic [15:0] rand_q();
		case ($urandom_range(9))
			0: return 16'(ONE_Q);
			1: return 16'($urandom);
			2: return 16'($urandom_range(3));
			default: return 16'($urandom_range(32767));
		endcase
	endfunction

	// Offer one pixel and hold it until transferred, idling first at random
	task automatic send_pixel(input pixel_t p);
		while (!calm && $urandom_range(99) < 18) begin
			pixel_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pixel_ch.valid <= 1'b1;
		pixel_ch.data <= p;
		@(posedge clk);
		while (!pixel_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		pixel_t p;
		int lim;
		arst_n = 1'b0;
		calm = 1'b0;
		pixel_ch.valid <= 1'b0;
		pixel_ch.data <= '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, gray, each dominant channel, each sextant, v of zero
		dir_q.push_back(make_rgb(8'd0, 8'd0, 8'd0));
		dir_q.push_back(make_rgb(8'd255, 8'd255, 8'd255));
		dir_q.push_back(make_rgb(8'd128, 8'd128, 8'd128));
		dir_q.push_back(make_rgb(8'd255, 8'd0, 8'd0));
		dir_q.push_back(make_rgb(8'd0, 8'd255, 8'd0));
		dir_q.push_back(make_rgb(8'd0, 8'd0, 8'd255));
		dir_q.push_back(make_rgb(8'd255, 8'd0, 8'd10));
		dir_q.push_back(make_rgb(8'd1, 8'd0, 8'd0));
		dir_q.push_back(make_rgb(8'd255, 8'd254, 8'd0));
		dir_q.push_back(make_rgb(8'd127, 8'd128, 8'd0));
		dir_q.push_back(make_hsl(16'd0, 16'd0, 16'd0));
		dir_q.push_back(make_hsl(16'd0, 16'd0, 16'(ONE_Q)));
		dir_q.push_back(make_hsl(16'(ONE_Q), 16'(ONE_Q), 16'd16384));
		dir_q.push_back(make_hsl(16'hFFFF, 16'hFFFF, 16'hFFFF));
		for (int k = 0; k < 6; k++)
			dir_q.push_back(make_hsl(16'(k * 5461 + 2000), 16'd30000, 16'd12000));
		dir_q.push_back(make_hsl(16'd32767, 16'd32768, 16'd20000));
		dir_q.push_back(make_hsl(16'd5000, 16'd0, 16'd1));
		dir_q.push_back(make_hsl(16'd100, 16'd32768, 16'd16385));
		foreach (dir_q[i]) send_pixel(dir_q[i]);

		// Random pixels, with a calm stretch and one drain pause midway
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= 600 && i < 900);
			if (i == 1000) begin
				pixel_ch.valid <= 1'b0;
				@(negedge clk);
				while (pending != 0) @(negedge clk);
			end
			if ($urandom_range(1))
				p = make_rgb(8'($urandom), 8'($urandom), 8'($urandom));
			else
				p = make_hsl(rand_q(), rand_q(), rand_q());
			send_pixel(p);
		end
		calm = 1'b0;
		pixel_ch.valid <= 1'b0;

		// Drain, then allow the pipeline depth to settle
		lim = 0;
		while (pending != 0 && lim < 100000) begin
			@(negedge clk);
			lim++;
		end
		repeat (4 * NUM_STAGES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
